[hw/rtl/assert_macros.svh]
// Assertion helpers for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[hw/rtl/pbosc_pkg.sv]
package pbosc_pkg;

  // Shared multiplier operand and product widths, multiplier step count and quotient width.
  localparam int MUL_A_W   = 40;
  localparam int MUL_B_W   = 32;
  localparam int MUL_P_W   = 72;
  localparam int MUL_STEPS = 4;
  localparam int QUO_W     = 16;

  // Fixed-point constants.
  localparam logic signed [17:0] ONE_Q16    = 18'sd65536;
  localparam logic signed [31:0] PI_Q28     = 32'sd843314857;
  localparam logic signed [31:0] TWO_PI_Q28 = 32'sd1686629714;
  localparam logic signed [25:0] PI2_Q20    = 26'sd10349030;
  localparam logic signed [39:0] SIN_C0     = -40'sd111403815550;
  localparam logic signed [39:0] SIN_C1     = 40'sd7279734326;
  localparam logic signed [39:0] SIN_C2     = -40'sd190770820;
  localparam logic signed [39:0] SIN_C3     = 40'sd2773289;
  localparam logic signed [39:0] SIN_C4     = -40'sd25638;
  localparam logic signed [39:0] SIN_C5     = 40'sd146;
  localparam logic [2:0]         SIN_H_LAST = 3'd4;

  // Wave codes.
  localparam logic [2:0] WAVE_SINE   = 3'd0;
  localparam logic [2:0] WAVE_SAW_DN = 3'd1;
  localparam logic [2:0] WAVE_SAW_UP = 3'd2;
  localparam logic [2:0] WAVE_PULSE  = 3'd3;
  localparam logic [2:0] WAVE_TRI    = 3'd4;

  // Register indexes.
  localparam logic [1:0] REG_INC    = 2'd0;
  localparam logic [1:0] REG_WAVE_A = 2'd1;
  localparam logic [1:0] REG_WAVE_B = 2'd2;
  localparam logic [1:0] REG_PW     = 2'd3;

  // Datapath step codes.
  typedef logic [3:0] step_t;
  localparam step_t ST_SIN_X  = 4'd0;
  localparam step_t ST_SIN_X2 = 4'd1;
  localparam step_t ST_SIN_H  = 4'd2;
  localparam step_t ST_SIN_B  = 4'd3;
  localparam step_t ST_SIN_F  = 4'd4;
  localparam step_t ST_DIV_P  = 4'd5;
  localparam step_t ST_SQ_P   = 4'd6;
  localparam step_t ST_DIV_Q  = 4'd7;
  localparam step_t ST_SQ_Q   = 4'd8;
  localparam step_t ST_TRI_A  = 4'd9;
  localparam step_t ST_TRI_AX = 4'd10;
  localparam step_t ST_TRI_Y  = 4'd11;
  localparam step_t ST_FIN    = 4'd12;

  typedef struct packed {
    logic       go;
    logic       load;
    step_t      step;
    logic       ch;
    logic [2:0] hk;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
  } dp_stat_t;

  // Horner coefficient for pass k, highest order first.
  function automatic logic signed [39:0] sin_coef(input logic [2:0] k);
    logic signed [39:0] c;
    unique case (k)
      3'd0:    c = SIN_C4;
      3'd1:    c = SIN_C3;
      3'd2:    c = SIN_C2;
      3'd3:    c = SIN_C1;
      default: c = SIN_C0;
    endcase
    return c;
  endfunction

  // Saturate to the signed Q2.16 range.
  function automatic logic signed [17:0] sat18(input logic signed [23:0] v);
    logic signed [17:0] r;
    if (v < -24'sd131072) begin
      r = -18'sd131072;
    end else if (v > 24'sd131071) begin
      r = 18'sd131071;
    end else begin
      r = v[17:0];
    end
    return r;
  endfunction

endpackage

[hw/rtl/pbosc_mul.sv]
module pbosc_mul
  import pbosc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic                      done,
  output logic signed [MUL_P_W-1:0] prod
);

  logic signed [MUL_A_W-1:0] a_q;
  logic        [MUL_B_W-1:0] b_q;
  logic [1:0]                cnt;
  logic                      busy;
  logic signed [8:0]         digit;
  logic signed [MUL_A_W+8:0] part;
  logic signed [MUL_P_W-1:0] prod_next;

  // Radix-256 multiply, most significant digit first; the top digit is signed.
  assign digit     = (cnt == 2'd0) ? $signed({b_q[MUL_B_W-1], b_q[MUL_B_W-1 -: 8]})
                                   : $signed({1'b0, b_q[MUL_B_W-1 -: 8]});
  assign part      = a_q * digit;
  assign prod_next = $signed({prod[MUL_P_W-9:0], 8'b0}) + MUL_P_W'(part);

  // Control flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 2'd1;
        if (cnt == 2'(MUL_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Operands and accumulator.
  always_ff @(posedge clk) begin
    if (start) begin
      a_q  <= a;
      b_q  <= b;
      prod <= '0;
    end else if (busy) begin
      b_q  <= {b_q[MUL_B_W-9:0], 8'b0};
      prod <= prod_next;
    end
  end

endmodule

[hw/rtl/pbosc_div.sv]
module pbosc_div
  import pbosc_pkg::*;
#(
  parameter int W = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [W-1:0]     num,
  input  logic [W-1:0]     den,
  output logic             done,
  output logic [QUO_W-1:0] quo
);

  logic [W:0]   rem;
  logic [W:0]   shifted;
  logic [W-1:0] den_q;
  logic [3:0]   cnt;
  logic         busy;
  logic         ge;

  // One restoring quotient bit per cycle.
  assign shifted = {rem[W-1:0], 1'b0};
  assign ge      = shifted >= {1'b0, den_q};

  // Control flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 4'd1;
        if (cnt == 4'(QUO_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= {1'b0, num};
      den_q <= den;
      quo   <= '0;
    end else if (busy) begin
      rem <= ge ? (shifted - {1'b0, den_q}) : shifted;
      quo <= {quo[QUO_W-2:0], ge};
    end
  end

endmodule

[hw/rtl/pbosc_dp.sv]
module pbosc_dp
  import pbosc_pkg::*;
#(
  parameter int PB = 32,
  parameter int SB = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic [30:0] inc,
  input  logic [2:0]  wave_a,
  input  logic [2:0]  wave_b,
  input  logic [15:0] pw_thresh,
  output logic [11:0] dac_a,
  output logic [11:0] dac_b,
  output logic        gate
);

  localparam int CW = 19 + SB;
  localparam logic [CW-1:0] MAXC = CW'((64'd1 << SB) - 64'd1);

  logic [31:0]         inc_ext;
  logic [PB-1:0]       dt;
  logic [PB-1:0]       phase;
  logic [PB+16:0]      pext;
  logic [16:0]         t2;
  logic signed [17:0]  s;
  logic [2:0]          wave;
  logic signed [17:0]  integ_a;
  logic signed [17:0]  integ_b;
  logic signed [17:0]  integ_sel;

  // Working registers.
  logic signed [23:0]  x;
  logic signed [24:0]  x2;
  logic signed [39:0]  acc;
  logic signed [25:0]  bq;
  logic [29:0]         a_tri;
  logic signed [49:0]  tax;
  logic signed [23:0]  vreg;
  logic signed [17:0]  blep_p;
  logic signed [17:0]  blep_q;
  logic [11:0]         code_a;
  logic [11:0]         code_b;
  logic                comb_done;

  // Units.
  logic                      mul_start;
  logic                      mul_done;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;
  logic                      div_start;
  logic                      div_done;
  logic [PB-1:0]             div_num;
  logic [QUO_W-1:0]          quo;

  // PolyBLEP region logic.
  logic          use_q;
  logic [PB-1:0] qph;
  logic [PB:0]   wrap_gap;
  logic          r1;
  logic          r2;

  logic signed [MUL_P_W-1:0] sq_rnd;
  logic [16:0]               sqr;
  logic [16:0]               u2;
  logic signed [18:0]        term;
  logic signed [25:0]        x2m;
  logic signed [MUL_P_W-1:0] sin_rnd;
  logic signed [MUL_P_W-1:0] tri_sum;

  // Channel value formation.
  logic signed [17:0] sgn;
  logic signed [19:0] sq_val;
  logic signed [17:0] tri_x;
  logic signed [23:0] saw_dn;
  logic signed [23:0] fin_v;
  logic signed [17:0] v18;
  logic signed [18:0] w19;
  logic [CW-1:0]      wsh;
  logic [CW-1:0]      cq;
  logic [CW-1:0]      cc;
  logic               gate_next;

  // Phase-derived values.
  assign inc_ext   = {1'b0, inc};
  assign dt        = inc_ext[31 -: PB];
  assign pext      = {phase, 17'b0};
  assign t2        = pext[PB+16:PB];
  assign s         = $signed({1'b0, t2}) - ONE_Q16;
  assign wave      = cmd.ch ? wave_b : wave_a;
  assign integ_sel = cmd.ch ? integ_b : integ_a;
  assign gate_next = phase[PB-1 -: 16] < pw_thresh;

  // The second correction looks at the phase moved by half a cycle.
  assign use_q    = (cmd.step == ST_DIV_Q) || (cmd.step == ST_SQ_Q);
  assign qph      = use_q ? {~phase[PB-1], phase[PB-2:0]} : phase;
  assign wrap_gap = {1'b1, {PB{1'b0}}} - {1'b0, qph};
  assign r1       = qph < dt;
  assign r2       = !r1 && (wrap_gap < {1'b0, dt});
  assign div_num  = r1 ? qph : wrap_gap[PB-1:0];

  // Correction term from the rounded square of the quotient.
  assign sq_rnd = prod + 72'sd32768;
  assign sqr    = sq_rnd[32:16];
  assign u2     = {quo, 1'b0};
  always_comb begin
    if (r1) begin
      term = $signed({2'b0, u2}) - $signed({2'b0, sqr}) - 19'sd65536;
    end else if (r2) begin
      term = $signed({2'b0, sqr}) - $signed({2'b0, u2}) + 19'sd65536;
    end else begin
      term = '0;
    end
  end

  assign x2m     = 26'(x2) - PI2_Q20;
  assign sin_rnd = prod + 72'sd8796093022208;
  assign tri_sum = MUL_P_W'(tax) + prod + 72'sd134217728;

  // Square, saw and final value selection.
  assign sgn    = (phase <= {1'b1, {(PB-1){1'b0}}}) ? ONE_Q16 : -ONE_Q16;
  assign sq_val = 20'(sgn) + 20'(blep_p) - 20'(blep_q);
  assign tri_x  = sat18(24'(sq_val));
  assign saw_dn = 24'sd65536 - $signed({7'b0, t2}) + 24'(blep_p);

  always_comb begin
    unique case (wave)
      WAVE_SINE:   fin_v = vreg;
      WAVE_SAW_DN: fin_v = saw_dn;
      WAVE_SAW_UP: fin_v = -saw_dn;
      WAVE_PULSE:  fin_v = 24'(sq_val);
      WAVE_TRI:    fin_v = vreg;
      default:     fin_v = '0;
    endcase
  end

  assign v18 = sat18(fin_v);

  // Map to a converter code with round half up and clamp.
  assign w19 = 19'(v18) + 19'sd65536;
  assign wsh = CW'(w19[17:0]) << (SB - 1);
  assign cq  = (wsh + CW'(32768)) >> 16;
  always_comb begin
    if (w19 <= 19'sd0) begin
      cc = '0;
    end else if (cq > MAXC) begin
      cc = MAXC;
    end else begin
      cc = cq;
    end
  end

  // Multiplier operand selection for each step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.step)
      ST_SIN_X: begin
        mul_a = MUL_A_W'(s);
        mul_b = PI_Q28;
      end
      ST_SIN_X2: begin
        mul_a = MUL_A_W'(x);
        mul_b = MUL_B_W'(x);
      end
      ST_SIN_H: begin
        mul_a = acc;
        mul_b = MUL_B_W'(x2);
      end
      ST_SIN_B: begin
        mul_a = MUL_A_W'(x2m);
        mul_b = MUL_B_W'(x);
      end
      ST_SIN_F: begin
        mul_a = acc;
        mul_b = MUL_B_W'(bq);
      end
      ST_SQ_P, ST_SQ_Q: begin
        mul_a = $signed(MUL_A_W'(quo));
        mul_b = $signed(MUL_B_W'(quo));
      end
      ST_TRI_A: begin
        mul_a = $signed(MUL_A_W'(dt));
        mul_b = TWO_PI_Q28;
      end
      ST_TRI_AX: begin
        mul_a = MUL_A_W'(tri_x);
        mul_b = $signed({2'b0, a_tri});
      end
      ST_TRI_Y: begin
        mul_a = MUL_A_W'(integ_sel);
        mul_b = 32'sd268435456 - $signed({2'b0, a_tri});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign div_start = cmd.go && ((cmd.step == ST_DIV_P) || (cmd.step == ST_DIV_Q));
  assign mul_start = cmd.go && !div_start && (cmd.step != ST_FIN);
  assign stat.done = mul_done || div_done || comb_done;

  pbosc_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  pbosc_div #(.W(PB)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (dt),
    .done  (div_done),
    .quo   (quo)
  );

  // Step completion for the final combine.
  always_ff @(posedge clk) begin
    if (rst) begin
      comb_done <= 1'b0;
    end else begin
      comb_done <= cmd.go && (cmd.step == ST_FIN);
    end
  end

  // Oscillator state: phase and one integrator per channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= '0;
      integ_a <= '0;
      integ_b <= '0;
    end else begin
      if (cmd.load) begin
        phase <= phase + dt;
      end
      if (stat.done && (cmd.step == ST_FIN)) begin
        if (cmd.ch) begin
          integ_b <= v18;
        end else begin
          integ_a <= v18;
        end
      end
    end
  end

  // Write back the result of the finished step.
  always_ff @(posedge clk) begin
    if (stat.done) begin
      unique case (cmd.step)
        ST_SIN_X: begin
          x   <= prod[47:24];
          acc <= SIN_C5;
        end
        ST_SIN_X2: x2 <= prod[44:20];
        ST_SIN_H:  acc <= $signed(prod[59:20]) + sin_coef(cmd.hk);
        ST_SIN_B:  bq <= prod[45:20];
        ST_SIN_F:  vreg <= sin_rnd[67:44];
        ST_SQ_P:   blep_p <= term[17:0];
        ST_SQ_Q:   blep_q <= term[17:0];
        ST_TRI_A:  a_tri <= prod[PB+29:PB];
        ST_TRI_AX: tax <= prod[49:0];
        ST_TRI_Y:  vreg <= tri_sum[51:28];
        ST_FIN: begin
          if (cmd.ch) begin
            code_b <= cc[11:0];
          end else begin
            code_a <= cc[11:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dac_a <= code_a;
      dac_b <= code_b;
      gate  <= gate_next;
    end
  end

endmodule

[hw/rtl/pbosc_ctrl.sv]
module pbosc_ctrl
  import pbosc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       strobe_valid,
  output logic       strobe_stall,
  input  logic       sample_strobe,
  output logic       result_valid,
  input  logic       result_stall,
  input  logic [2:0] wave_a,
  input  logic [2:0] wave_b,
  output dp_cmd_t    cmd,
  input  dp_stat_t   stat
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_LOAD  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  step_t      step;
  step_t      step_next;
  logic       ch;
  logic       ch_next;
  logic [2:0] hk;
  logic [2:0] hk_next;
  logic       load;
  logic [2:0] wave;
  step_t      follow;

  // First step of a channel for its wave.
  function automatic step_t first_step(input logic [2:0] w);
    step_t r;
    unique case (w)
      WAVE_SINE:                                       r = ST_SIN_X;
      WAVE_SAW_DN, WAVE_SAW_UP, WAVE_PULSE, WAVE_TRI:  r = ST_DIV_P;
      default:                                         r = ST_FIN;
    endcase
    return r;
  endfunction

  assign wave = ch ? wave_b : wave_a;

  // Step sequence within one channel.
  always_comb begin
    unique case (step)
      ST_SIN_X:  follow = ST_SIN_X2;
      ST_SIN_X2: follow = ST_SIN_H;
      ST_SIN_H:  follow = (hk == SIN_H_LAST) ? ST_SIN_B : ST_SIN_H;
      ST_SIN_B:  follow = ST_SIN_F;
      ST_DIV_P:  follow = ST_SQ_P;
      ST_SQ_P:   follow = ((wave == WAVE_PULSE) || (wave == WAVE_TRI)) ? ST_DIV_Q : ST_FIN;
      ST_DIV_Q:  follow = ST_SQ_Q;
      ST_SQ_Q:   follow = (wave == WAVE_TRI) ? ST_TRI_A : ST_FIN;
      ST_TRI_A:  follow = ST_TRI_AX;
      ST_TRI_AX: follow = ST_TRI_Y;
      default:   follow = ST_FIN;
    endcase
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    step_next  = step;
    ch_next    = ch;
    hk_next    = hk;
    load       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (strobe_valid && sample_strobe) begin
          ch_next    = 1'b0;
          hk_next    = '0;
          step_next  = first_step(wave_a);
          state_next = S_ISSUE;
        end
      end
      S_ISSUE: state_next = S_WAIT;
      S_WAIT: begin
        if (stat.done) begin
          if (step == ST_FIN) begin
            if (!ch) begin
              ch_next    = 1'b1;
              hk_next    = '0;
              step_next  = first_step(wave_b);
              state_next = S_ISSUE;
            end else begin
              state_next = S_LOAD;
            end
          end else begin
            step_next  = follow;
            state_next = S_ISSUE;
            if (step == ST_SIN_H) begin
              hk_next = hk + 3'd1;
            end
          end
        end
      end
      default: begin
        if (!result_valid || !result_stall) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step         <= ST_FIN;
      ch           <= 1'b0;
      hk           <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      ch    <= ch_next;
      hk    <= hk_next;
      if (load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  assign strobe_stall = (state != S_IDLE);
  assign cmd.go       = (state == S_ISSUE);
  assign cmd.load     = load;
  assign cmd.step     = step;
  assign cmd.ch       = ch;
  assign cmd.hk       = hk;

endmodule

[hw/rtl/polyblep_oscillator_two_channel.sv]
// Channel    Handshake                 Payload
// strobe     strobe_valid/strobe_stall sample_strobe
// result     result_valid/result_stall dac_a, dac_b, gate
// cfg        cfg_valid/cfg_ready       cfg_index, cfg_data
//
// The time a sample tick takes from acceptance to the next free slot depends on the
// wave of each channel (sine, saws, pulse, triangle or unused code) and comes mostly
// from the multiplier, shared by both channels, and from the divider.
// A tick with sample_strobe low is taken without a stall and changes nothing.
// Reset (rst, synchronous) clears phase, integrators and configuration registers to their defaults.
// A stalled result holds; the next tick is computed meanwhile and waits for the register.
module polyblep_oscillator_two_channel
  import pbosc_pkg::*;
#(
  parameter int SAMPLE_BITS = 12,
  parameter int PHASE_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        strobe_valid,
  output logic        strobe_stall,
  input  logic        sample_strobe,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [11:0] dac_a,
  output logic [11:0] dac_b,
  output logic        gate,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  logic [30:0] phase_increment;
  logic [2:0]  wave_a;
  logic [2:0]  wave_b;
  logic [15:0] pw_thresh;
  dp_cmd_t     cmd;
  dp_stat_t    stat;

  // Configuration registers.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_increment <= '0;
      wave_a          <= WAVE_SINE;
      wave_b          <= WAVE_TRI;
      pw_thresh       <= 16'd32768;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_INC:    phase_increment <= cfg_data;
        REG_WAVE_A: wave_a <= cfg_data[2:0];
        REG_WAVE_B: wave_b <= cfg_data[2:0];
        REG_PW:     pw_thresh <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  pbosc_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .strobe_valid  (strobe_valid),
    .strobe_stall  (strobe_stall),
    .sample_strobe (sample_strobe),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .wave_a        (wave_a),
    .wave_b        (wave_b),
    .cmd           (cmd),
    .stat          (stat)
  );

  pbosc_dp #(.PB(PHASE_BITS), .SB(SAMPLE_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .inc       (phase_increment),
    .wave_a    (wave_a),
    .wave_b    (wave_b),
    .pw_thresh (pw_thresh),
    .dac_a     (dac_a),
    .dac_b     (dac_b),
    .gate      (gate)
  );

endmodule

[hw/rtl/pbosc_chk.sv]
`include "assert_macros.svh"

module pbosc_chk (
  input logic        clk,
  input logic        rst,
  input logic        strobe_valid,
  input logic        strobe_stall,
  input logic        sample_strobe,
  input logic        result_valid,
  input logic        result_stall,
  input logic [11:0] dac_a,
  input logic [11:0] dac_b,
  input logic        gate
);

  // A rendering tick keeps the input side busy on the next cycle.
  `ASSERT_NEXT(a_tick_busy, clk, rst, strobe_valid && !strobe_stall && sample_strobe, strobe_stall)

  // A new result only appears after a rendering period.
  `ASSERT_IMPLY(a_result_after_work, clk, rst, $rose(result_valid), $past(strobe_stall))

  // A stalled result transaction stays offered.
  `ASSERT_NEXT(a_result_holds, clk, rst, result_valid && result_stall, result_valid)

  // A stalled result keeps its payload.
  `ASSERT_NEXT(a_payload_holds, clk, rst, result_valid && result_stall, $stable(dac_a) && $stable(dac_b) && $stable(gate))

endmodule

bind polyblep_oscillator_two_channel pbosc_chk u_chk (
  .clk           (clk),
  .rst           (rst),
  .strobe_valid  (strobe_valid),
  .strobe_stall  (strobe_stall),
  .sample_strobe (sample_strobe),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .dac_a         (dac_a),
  .dac_b         (dac_b),
  .gate          (gate)
);
